// File: rtl/cgrm_pkg.sv
// Shared types, constants and helpers for the crosspoint gain ramp mixer.
// No dependencies; every other file but cgrm_ram imports this package.
package cgrm_pkg;

    localparam int NUM_SOURCES  = 64;
    localparam int NUM_SPEAKERS = 64;
    localparam int SAMPLE_BITS  = 24;
    localparam int XP_COUNT     = NUM_SOURCES * NUM_SPEAKERS;
    localparam int XP_AW        = $clog2(XP_COUNT);

    localparam int GAIN_W  = 24;
    localparam int SLOPE_W = 25;
    localparam int MODE_W  = 2;
    localparam int STATE_W = MODE_W + SLOPE_W + GAIN_W;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    // Ramp modes kept per crosspoint
    localparam logic [MODE_W-1:0] MODE_SETTLED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SILENCE = 2'd3;

    // Opcodes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_MIX = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_SMOOTH_EN = 2'd0;
    localparam logic [1:0] REG_FACTOR    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_SHIFT     = 2'd3;

    typedef struct packed {
        logic                          opcode;
        logic [5:0]                    source_index;
        logic [5:0]                    speaker_index;
        logic [15:0]                   target_gain;
        logic                          first_of_block;
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic signed [31:0]            bus_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] bus_out;
        logic [15:0]        gain_now;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic             clear;
        logic [XP_AW-1:0] clr_addr;
        logic             accept;
        logic             dec;
        logic             upd;
        logic             fin;
        logic             load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_set;
    } status_t;

    function automatic logic [XP_AW-1:0] xp_index(input logic [5:0] src,
                                                   input logic [5:0] spk);
        return XP_AW'(src) * XP_AW'(NUM_SPEAKERS) + XP_AW'(spk);
    endfunction

    function automatic logic xp_valid(input logic [5:0] src, input logic [5:0] spk);
        return (32'(src) < NUM_SOURCES) && (32'(spk) < NUM_SPEAKERS);
    endfunction

endpackage

// File: rtl/crosspoint_gain_ramp_mixer.sv
// Crosspoint gain ramp mixer, top level. Depends on cgrm_pkg, cgrm_ctrl, cgrm_dp.
// A mix transaction passes through the DEC, UPD, FIN and OUT states before m_valid
// rises; a set transaction writes its target in DEC and goes back to idle with no output.
// One transaction is in flight at a time, so a new item is taken only after the last one
// has gone through the memory read, two registered multiplies and the write-back.
// Reset: synchronous; after reset a clearing sweep zeroes all 4096 entries of the memories.
module crosspoint_gain_ramp_mixer import cgrm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);
    cmd_t    cmd;
    status_t status;

    cgrm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    cgrm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_data(s_data), .cmd(cmd), .status(status), .m_data(m_data)
    );
endmodule

// File: rtl/cgrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/cgrm_ctrl.sv
// Controller: clearing sweep, item sequencing and output register handshake.
// Depends on cgrm_pkg.
module cgrm_ctrl import cgrm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DEC   = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [XP_AW-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == XP_AW'(XP_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.dec    = 1'b1;
                state_next = status.is_set ? ST_IDLE : ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

// File: rtl/cgrm_dp.sv
// Datapath: config registers, crosspoint memories, ramp/smoothing math, mixing.
// Depends on cgrm_pkg and cgrm_ram.
module cgrm_dp import cgrm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_wdata,
    input  in_item_t  s_data,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t m_data
);
    // Configuration
    logic        smooth_en_reg;
    logic [15:0] factor_reg;
    logic [15:0] thr_reg;
    logic [3:0]  shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_en_reg <= 1'b0;
            factor_reg    <= 16'd65470;
            thr_reg       <= 16'd66;
            shift_reg     <= 4'd9;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SMOOTH_EN: smooth_en_reg <= cfg_wdata[0];
                REG_FACTOR:    factor_reg    <= cfg_wdata;
                REG_THRESHOLD: thr_reg       <= cfg_wdata;
                REG_SHIFT:     shift_reg     <= cfg_wdata[3:0];
                default:       ;
            endcase
        end
    end

    logic [GAIN_W-1:0] thr24;
    assign thr24 = {thr_reg, 8'd0};

    // Latched transaction
    in_item_t         item_reg;
    logic [XP_AW-1:0] idx_reg;
    logic             ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
            idx_reg  <= xp_index(s_data.source_index, s_data.speaker_index);
            ok_reg   <= xp_valid(s_data.source_index, s_data.speaker_index);
        end
    end

    assign status.is_set = (item_reg.opcode == OP_SET);

    // Memories; read issued in the accept cycle
    logic [XP_AW-1:0]   raddr;
    logic [15:0]        tgt_rd;
    logic [STATE_W-1:0] st_rd;
    logic               tgt_we, st_we;
    logic [XP_AW-1:0]   tgt_wa, st_wa;
    logic [15:0]        tgt_wd;
    logic [STATE_W-1:0] st_wd;
    logic [STATE_W-1:0] st_new;

    assign raddr  = xp_index(s_data.source_index, s_data.speaker_index);
    assign tgt_we = cmd.clear || (cmd.dec && item_reg.opcode == OP_SET && ok_reg);
    assign tgt_wa = cmd.clear ? cmd.clr_addr : idx_reg;
    assign tgt_wd = cmd.clear ? 16'd0 : item_reg.target_gain;
    assign st_we  = cmd.clear || (cmd.fin && ok_reg);
    assign st_wa  = cmd.clear ? cmd.clr_addr : idx_reg;
    assign st_wd  = cmd.clear ? '0 : st_new;

    cgrm_ram #(.WIDTH(16), .DEPTH(XP_COUNT)) u_tgt_ram (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
        .raddr(raddr), .rdata(tgt_rd)
    );

    cgrm_ram #(.WIDTH(STATE_W), .DEPTH(XP_COUNT)) u_state_ram (
        .aclk(aclk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .raddr(raddr), .rdata(st_rd)
    );

    // Stage 1: block-start ramp decision
    logic [GAIN_W-1:0]         g_rd, t24, mag, smag, g_d;
    logic signed [SLOPE_W-1:0] slope_rd, slope_d;
    logic [MODE_W-1:0]         mode_rd, mode_d;

    assign g_rd     = st_rd[GAIN_W-1:0];
    assign slope_rd = st_rd[GAIN_W +: SLOPE_W];
    assign mode_rd  = st_rd[GAIN_W+SLOPE_W +: MODE_W];
    assign t24      = {tgt_rd, 8'd0};
    assign mag      = (g_rd >= t24) ? (g_rd - t24) : (t24 - g_rd);
    assign smag     = mag >> shift_reg;

    always_comb begin
        g_d     = g_rd;
        slope_d = slope_rd;
        mode_d  = mode_rd;
        if (item_reg.first_of_block) begin
            if (smag == '0 || mag < thr24) begin
                g_d    = t24;
                mode_d = MODE_SETTLED;
            end else if (!smooth_en_reg) begin
                slope_d = (t24 >= g_rd) ? $signed({1'b0, smag})
                                        : -$signed({1'b0, smag});
                mode_d  = MODE_LINEAR;
            end else begin
                mode_d = (t24 < thr24) ? MODE_SILENCE : MODE_SMOOTH;
            end
        end
    end

    logic [GAIN_W-1:0]         g_reg, t24_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic [MODE_W-1:0]         mode_reg;

    always_ff @(posedge aclk) begin
        if (cmd.dec) begin
            g_reg     <= g_d;
            t24_reg   <= t24;
            slope_reg <= slope_d;
            mode_reg  <= mode_d;
        end
    end

    // Stage 2: linear step with clamp, smoothing product
    logic signed [GAIN_W+1:0] ng, ng_c;
    logic [GAIN_W-1:0]        dmag;
    logic [GAIN_W-1:0]        lin_reg;
    logic [GAIN_W+15:0]       sprod_reg;
    logic                     ge_reg;

    assign ng   = $signed({2'b00, g_reg}) + (GAIN_W+2)'(slope_reg);
    assign dmag = (g_reg >= t24_reg) ? (g_reg - t24_reg) : (t24_reg - g_reg);

    always_comb begin
        ng_c = ng;
        if (!slope_reg[SLOPE_W-1]) begin
            if (ng_c > $signed({2'b00, t24_reg})) ng_c = $signed({2'b00, t24_reg});
        end else begin
            if (ng_c < $signed({2'b00, t24_reg})) ng_c = $signed({2'b00, t24_reg});
        end
        if (ng_c < 0) ng_c = '0;
        if (ng_c > $signed({2'b00, GAIN_MAX})) ng_c = $signed({2'b00, GAIN_MAX});
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            lin_reg   <= ng_c[GAIN_W-1:0];
            sprod_reg <= dmag * factor_reg;
            ge_reg    <= (g_reg >= t24_reg);
        end
    end

    // Stage 3: new gain, state write-back, sample product
    logic [GAIN_W-1:0] smoothed, g_new;
    logic              apply;
    logic [15:0]       g16;

    assign smoothed = ge_reg ? (t24_reg + sprod_reg[GAIN_W+15:16])
                             : (t24_reg - sprod_reg[GAIN_W+15:16]);

    always_comb begin
        g_new = g_reg;
        apply = 1'b0;
        case (mode_reg)
            MODE_SETTLED: apply = (g_reg >= thr24);
            MODE_LINEAR: begin
                g_new = lin_reg;
                apply = 1'b1;
            end
            MODE_SMOOTH: begin
                g_new = smoothed;
                apply = 1'b1;
            end
            default: begin
                if (g_reg >= thr24) begin
                    g_new = smoothed;
                    apply = 1'b1;
                end
            end
        endcase
    end

    assign st_new = {mode_reg, slope_reg, g_new};
    assign g16    = g_new[GAIN_W-1:8];

    logic signed [SAMPLE_BITS+16:0] prod_reg;
    logic                           apply_reg;
    logic [15:0]                    g16_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            prod_reg  <= item_reg.in_sample * $signed({1'b0, g16});
            apply_reg <= apply && ok_reg;
            g16_reg   <= g16;
        end
    end

    // Stage 4: round half up, saturating bus add
    logic signed [SAMPLE_BITS+17:0] pr;
    logic signed [SAMPLE_BITS+1:0]  rnd;
    logic signed [32:0]             sum;
    logic signed [31:0]             sat;
    out_item_t                      out_reg;

    assign pr  = (SAMPLE_BITS+18)'(prod_reg) + (SAMPLE_BITS+18)'(32768);
    assign rnd = pr[SAMPLE_BITS+17:16];
    assign sum = 33'(item_reg.bus_in) + 33'(rnd);

    always_comb begin
        if (sum > 33'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (sum < -33'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.bus_out  <= apply_reg ? sat : item_reg.bus_in;
            out_reg.gain_now <= apply_reg ? g16_reg : 16'd0;
        end
    end

    assign m_data = out_reg;
endmodule

// File: rtl/cgrm_checker.sv
// Port-level checker for the crosspoint gain ramp mixer, bound to the top level.
// Depends on cgrm_pkg.
module cgrm_checker import cgrm_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Clearing sweep blocks input right after reset
    a_reset_blocks: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready during clearing sweep");

    // One transaction in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back-to-back accept");
endmodule

bind crosspoint_gain_ramp_mixer cgrm_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
